@@ rtl/petok_pkg.sv @@
`default_nettype none

package petok_pkg;

  // Longest token text held in the token store
  localparam int TOKEN_SIZE = 32;

  // Token kinds
  localparam logic [5:0] K_END   = 6'd0;
  localparam logic [5:0] K_ANY   = 6'd1;
  localparam logic [5:0] K_WHITE = 6'd2;
  localparam logic [5:0] K_NEWL  = 6'd3;
  localparam logic [5:0] K_DIGIT = 6'd4;
  localparam logic [5:0] K_ALPHA = 6'd5;
  localparam logic [5:0] K_SQ    = 6'd6;
  localparam logic [5:0] K_DQ    = 6'd7;
  localparam logic [5:0] K_NOT   = 6'd8;
  localparam logic [5:0] K_POUND = 6'd9;
  localparam logic [5:0] K_MOD   = 6'd10;
  localparam logic [5:0] K_AND   = 6'd11;
  localparam logic [5:0] K_LPAR  = 6'd12;
  localparam logic [5:0] K_RPAR  = 6'd13;
  localparam logic [5:0] K_MULT  = 6'd14;
  localparam logic [5:0] K_ADD   = 6'd15;
  localparam logic [5:0] K_COMMA = 6'd16;
  localparam logic [5:0] K_SUB   = 6'd17;
  localparam logic [5:0] K_DIV   = 6'd18;
  localparam logic [5:0] K_COLON = 6'd19;
  localparam logic [5:0] K_LESS  = 6'd20;
  localparam logic [5:0] K_EQUAL = 6'd21;
  localparam logic [5:0] K_GREAT = 6'd22;
  localparam logic [5:0] K_QMARK = 6'd23;
  localparam logic [5:0] K_BSL   = 6'd24;
  localparam logic [5:0] K_XOR   = 6'd25;
  localparam logic [5:0] K_OR    = 6'd26;
  localparam logic [5:0] K_COMPL = 6'd27;
  localparam logic [5:0] K_NEQ   = 6'd28;
  localparam logic [5:0] K_RSH   = 6'd29;
  localparam logic [5:0] K_GEQ   = 6'd30;
  localparam logic [5:0] K_LSH   = 6'd31;
  localparam logic [5:0] K_LEQ   = 6'd32;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_LONG = 2'd1;
  localparam logic [1:0] ERR_OPEN = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef enum logic [1:0] {SRC_LIT, SRC_BYTE, SRC_RAM} src_e;

  typedef struct packed {
    logic [7:0] ch;
    logic [5:0] kind;
    logic       last;
    logic [1:0] err;
  } item_t;

  // Controller to datapath
  typedef struct packed {
    logic  take;
    logic  store;
    logic  close;
    logic  restart;
    logic  clr;
    logic  quote_ld;
    logic  pop;
    logic  push;
    src_e  src;
    item_t item;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       eoi;
    logic [5:0] cls;
    logic       is_eq;
    logic       is_gt;
    logic       is_lt;
    logic       is_star;
    logic       is_slash;
    logic       is_bsl;
    logic       is_nl;
    logic       is_quote;
    logic       cnt_cap;
    logic       str_room;
    logic       dump_last;
    logic       out_free;
  } stat_t;

  // Character class of a source byte
  function automatic logic [5:0] byte_class(logic [7:0] b);
    logic [5:0] k;
    k = K_ANY;
    if (b[7]) begin
      k = K_ANY;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      k = K_DIGIT;
    end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F) begin
      k = K_ALPHA;
    end else begin
      case (b)
        8'h00:        k = K_END;
        8'h09, 8'h20: k = K_WHITE;
        8'h0A, 8'h14: k = K_NEWL;
        8'h21:        k = K_NOT;
        8'h22:        k = K_DQ;
        8'h23:        k = K_POUND;
        8'h25:        k = K_MOD;
        8'h26:        k = K_AND;
        8'h27:        k = K_SQ;
        8'h28:        k = K_LPAR;
        8'h29:        k = K_RPAR;
        8'h2A:        k = K_MULT;
        8'h2B:        k = K_ADD;
        8'h2C:        k = K_COMMA;
        8'h2D:        k = K_SUB;
        8'h2F:        k = K_DIV;
        8'h3A:        k = K_COLON;
        8'h3C:        k = K_LESS;
        8'h3D:        k = K_EQUAL;
        8'h3E:        k = K_GREAT;
        8'h3F:        k = K_QMARK;
        8'h5C:        k = K_BSL;
        8'h5E:        k = K_XOR;
        8'h7C:        k = K_OR;
        8'h7E:        k = K_COMPL;
        default:      k = K_ANY;
      endcase
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/petok_if.sv @@
`default_nettype none

interface petok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       end_of_input;

  modport source (output valid, output src_byte, output end_of_input, input ready);
  modport sink (input valid, input src_byte, input end_of_input, output ready);
endinterface

interface petok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tok_char;
  logic [5:0] tok_kind;
  logic       tok_last;
  logic [1:0] tok_error;

  modport source (output valid, output tok_char, output tok_kind, output tok_last,
                  output tok_error, input ready);
  modport sink (input valid, input tok_char, input tok_kind, input tok_last,
                input tok_error, output ready);
endinterface

`default_nettype wire

@@ rtl/petok_ram.sv @@
`default_nettype none

module petok_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/petok_dp.sv @@
`default_nettype none

module petok_dp #(
  parameter int TokenSize = petok_pkg::TOKEN_SIZE
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire petok_pkg::cmd_t  cmd_i,
  output petok_pkg::stat_t      stat_o,
  input  wire logic [7:0]       src_byte_i,
  input  wire logic             end_of_input_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output petok_pkg::item_t      out_item_o
);

  localparam int CW = $clog2(TokenSize + 1);
  localparam int AW = $clog2(TokenSize);
  localparam logic [CW-1:0] SizeM1 = CW'(TokenSize - 1);
  localparam logic [CW-1:0] SizeM2 = CW'(TokenSize - 2);
  localparam logic [CW-1:0] SizeW  = CW'(TokenSize);

  logic [7:0]    byte_q, quote_q;
  logic          eoi_q;
  logic [CW-1:0] cnt_q, cnt_d, rd_q, rd_d, close_at;
  logic          we;
  logic [CW-1:0] waddr;
  logic [7:0]    rdata;
  logic          out_valid_q;
  logic          out_free;
  petok_pkg::item_t out_q;

  // Hold the accepted byte and the open quote
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      byte_q <= src_byte_i;
      eoi_q  <= end_of_input_i;
    end
    if (cmd_i.quote_ld) begin
      quote_q <= byte_q;
    end
  end

  // Store write address and fill count
  always_comb begin
    close_at = (cnt_q < SizeW) ? cnt_q : SizeM1;
    we       = cmd_i.store | cmd_i.close | cmd_i.restart;
    waddr    = cnt_q;
    cnt_d    = cnt_q;
    if (cmd_i.restart) begin
      waddr = '0;
      cnt_d = CW'(1);
    end else if (cmd_i.close) begin
      waddr = close_at;
      cnt_d = close_at + CW'(1);
    end else if (cmd_i.store) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.clr || (cmd_i.pop && stat_o.dump_last)) begin
      cnt_d = '0;
    end
  end

  // Advance the read pointer, rewind after the last character
  always_comb begin
    rd_d = rd_q;
    if (cmd_i.pop) begin
      rd_d = stat_o.dump_last ? '0 : rd_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  petok_ram #(
    .Width (8),
    .Depth (TokenSize)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr[AW-1:0]),
    .wdata_i (byte_q),
    .raddr_i (rd_d[AW-1:0]),
    .rdata_o (rdata)
  );

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.kind <= cmd_i.item.kind;
      out_q.last <= cmd_i.item.last;
      out_q.err  <= cmd_i.item.err;
      unique case (cmd_i.src)
        petok_pkg::SRC_BYTE: out_q.ch <= byte_q;
        petok_pkg::SRC_RAM:  out_q.ch <= rdata;
        default:             out_q.ch <= cmd_i.item.ch;
      endcase
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Status toward the controller
  always_comb begin
    stat_o.eoi       = eoi_q;
    stat_o.cls       = petok_pkg::byte_class(byte_q);
    stat_o.is_eq     = byte_q == petok_pkg::CH_EQ;
    stat_o.is_gt     = byte_q == petok_pkg::CH_GT;
    stat_o.is_lt     = byte_q == petok_pkg::CH_LT;
    stat_o.is_star   = byte_q == petok_pkg::CH_STAR;
    stat_o.is_slash  = byte_q == petok_pkg::CH_SLASH;
    stat_o.is_bsl    = byte_q == petok_pkg::CH_BSL;
    stat_o.is_nl     = byte_q == petok_pkg::CH_NL;
    stat_o.is_quote  = byte_q == quote_q;
    stat_o.cnt_cap   = cnt_q == SizeM1;
    stat_o.str_room  = cnt_q < SizeM2;
    stat_o.dump_last = (rd_q + CW'(1)) == cnt_q;
    stat_o.out_free  = out_free;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= SizeW)
    else $error("token count beyond store size");
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> out_free)
    else $error("push into an occupied output register");
  a_pop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (rd_q < cnt_q))
    else $error("store read past fill count");

endmodule

`default_nettype wire

@@ rtl/petok_ctrl.sv @@
`default_nettype none

module petok_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire petok_pkg::stat_t stat_i,
  output petok_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {S_IN, S_EVAL, S_DUMP, S_CHA, S_CHB, S_TAIL} state_e;
  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_STR, M_ESC, M_NOT, M_GT, M_LT, M_EQ, M_SLASH, M_BLOCK, M_STAR, M_LINE
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic [5:0] pk_q, pk_d;
  logic       ovf_q, ovf_d;
  logic       dump_q, dump_d, a_v_q, a_v_d, b_v_q, b_v_d, idle_q, idle_d;
  logic [1:0] derr_q, derr_d;
  petok_pkg::item_t a_q, a_d, b_q, b_d;
  logic idle_req, idle_emit, is_word;

  function automatic petok_pkg::item_t lit(logic [7:0] ch, logic [5:0] kind,
                                           logic last, logic [1:0] err);
    petok_pkg::item_t it;
    it.ch   = ch;
    it.kind = kind;
    it.last = last;
    it.err  = err;
    return it;
  endfunction

  function automatic state_e chain(logic av, logic bv, logic iv);
    state_e s;
    if (av)      s = S_CHA;
    else if (bv) s = S_CHB;
    else if (iv) s = S_TAIL;
    else         s = S_IN;
    return s;
  endfunction

  assign is_word = stat_i.cls == petok_pkg::K_ALPHA || stat_i.cls == petok_pkg::K_DIGIT;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    mode_d   = mode_q;
    pk_d     = pk_q;
    ovf_d    = ovf_q;
    dump_d   = dump_q;
    derr_d   = derr_q;
    a_v_d    = a_v_q;
    a_d      = a_q;
    b_v_d    = b_v_q;
    b_d      = b_q;
    idle_d   = idle_q;
    idle_req = 1'b0;
    idle_emit = 1'b0;
    in_ready_o = state_q == S_IN;

    unique case (state_q)
      S_IN: begin
        cmd_o.take = in_valid_i;
        if (in_valid_i) state_d = S_EVAL;
      end

      S_EVAL: begin
        dump_d = 1'b0;
        derr_d = petok_pkg::ERR_NONE;
        a_v_d  = 1'b0;
        b_v_d  = 1'b0;
        idle_d = 1'b0;
        if (stat_i.eoi) begin
          // Flush the pending token, then the end token
          mode_d = M_IDLE;
          b_v_d  = 1'b1;
          b_d    = lit(petok_pkg::CH_NUL, petok_pkg::K_END, 1'b1, petok_pkg::ERR_NONE);
          cmd_o.clr = mode_q != M_WORD;
          unique case (mode_q)
            M_WORD: dump_d = 1'b1;
            M_STR, M_ESC, M_LINE: begin
              a_v_d = 1'b1;
              a_d = lit(petok_pkg::CH_NL, petok_pkg::K_NEWL, 1'b1, petok_pkg::ERR_NONE);
            end
            M_NOT: begin
              a_v_d = 1'b1;
              a_d = lit(petok_pkg::CH_BANG, petok_pkg::K_NOT, 1'b1, petok_pkg::ERR_NONE);
            end
            M_GT: begin
              a_v_d = 1'b1;
              a_d = lit(petok_pkg::CH_GT, petok_pkg::K_GREAT, 1'b1, petok_pkg::ERR_NONE);
            end
            M_LT: begin
              a_v_d = 1'b1;
              a_d = lit(petok_pkg::CH_LT, petok_pkg::K_LESS, 1'b1, petok_pkg::ERR_NONE);
            end
            M_EQ: begin
              a_v_d = 1'b1;
              a_d = lit(petok_pkg::CH_EQ, petok_pkg::K_ANY, 1'b1, petok_pkg::ERR_NONE);
            end
            M_SLASH: begin
              a_v_d = 1'b1;
              a_d = lit(petok_pkg::CH_SLASH, petok_pkg::K_DIV, 1'b1, petok_pkg::ERR_NONE);
            end
            M_BLOCK, M_STAR: begin
              a_v_d = 1'b1;
              a_d = lit(petok_pkg::CH_SPACE, petok_pkg::K_WHITE, 1'b1, petok_pkg::ERR_OPEN);
            end
            default: ;
          endcase
          state_d = dump_d ? S_DUMP : chain(a_v_d, 1'b1, 1'b0);
        end else begin
          unique case (mode_q)
            M_WORD: begin
              dump_d = 1'b1;
              if (is_word) begin
                cmd_o.store = 1'b1;
                dump_d = stat_i.cnt_cap;
                if (stat_i.cnt_cap) mode_d = M_IDLE;
              end else begin
                mode_d = M_IDLE;
                idle_d = 1'b1;
              end
            end
            M_STR: begin
              if (stat_i.is_quote) begin
                cmd_o.close = 1'b1;
                dump_d = 1'b1;
                derr_d = ovf_q ? petok_pkg::ERR_LONG : petok_pkg::ERR_NONE;
                ovf_d  = 1'b0;
                mode_d = M_IDLE;
              end else if (stat_i.is_nl) begin
                cmd_o.clr = 1'b1;
                ovf_d  = 1'b0;
                a_v_d  = 1'b1;
                a_d = lit(petok_pkg::CH_NL, petok_pkg::K_NEWL, 1'b1, petok_pkg::ERR_NONE);
                mode_d = M_IDLE;
              end else begin
                cmd_o.store = stat_i.str_room;
                if (!stat_i.str_room) ovf_d = 1'b1;
                if (stat_i.is_bsl) mode_d = M_ESC;
              end
            end
            M_ESC: begin
              cmd_o.store = stat_i.str_room;
              if (!stat_i.str_room) ovf_d = 1'b1;
              mode_d = M_STR;
            end
            M_NOT: begin
              mode_d = M_IDLE;
              a_v_d  = 1'b1;
              if (stat_i.is_eq) begin
                a_d = lit(petok_pkg::CH_BANG, petok_pkg::K_NEQ, 1'b0, petok_pkg::ERR_NONE);
                b_v_d = 1'b1;
                b_d = lit(petok_pkg::CH_EQ, petok_pkg::K_NEQ, 1'b1, petok_pkg::ERR_NONE);
              end else begin
                a_d = lit(petok_pkg::CH_BANG, petok_pkg::K_NOT, 1'b1, petok_pkg::ERR_NONE);
                idle_d = 1'b1;
              end
            end
            M_GT: begin
              mode_d = M_IDLE;
              a_v_d  = 1'b1;
              if (stat_i.is_gt || stat_i.is_eq) begin
                a_d = lit(petok_pkg::CH_GT, stat_i.is_gt ? petok_pkg::K_RSH : petok_pkg::K_GEQ,
                          1'b0, petok_pkg::ERR_NONE);
                b_v_d = 1'b1;
                b_d = lit(stat_i.is_gt ? petok_pkg::CH_GT : petok_pkg::CH_EQ,
                          stat_i.is_gt ? petok_pkg::K_RSH : petok_pkg::K_GEQ,
                          1'b1, petok_pkg::ERR_NONE);
              end else begin
                a_d = lit(petok_pkg::CH_GT, petok_pkg::K_GREAT, 1'b1, petok_pkg::ERR_NONE);
                idle_d = 1'b1;
              end
            end
            M_LT: begin
              mode_d = M_IDLE;
              a_v_d  = 1'b1;
              if (stat_i.is_lt || stat_i.is_eq) begin
                a_d = lit(petok_pkg::CH_LT, stat_i.is_lt ? petok_pkg::K_LSH : petok_pkg::K_LEQ,
                          1'b0, petok_pkg::ERR_NONE);
                b_v_d = 1'b1;
                b_d = lit(stat_i.is_lt ? petok_pkg::CH_LT : petok_pkg::CH_EQ,
                          stat_i.is_lt ? petok_pkg::K_LSH : petok_pkg::K_LEQ,
                          1'b1, petok_pkg::ERR_NONE);
              end else begin
                a_d = lit(petok_pkg::CH_LT, petok_pkg::K_LESS, 1'b1, petok_pkg::ERR_NONE);
                idle_d = 1'b1;
              end
            end
            M_EQ: begin
              mode_d = M_IDLE;
              a_v_d  = 1'b1;
              if (stat_i.is_eq) begin
                a_d = lit(petok_pkg::CH_EQ, petok_pkg::K_EQUAL, 1'b0, petok_pkg::ERR_NONE);
                b_v_d = 1'b1;
                b_d = lit(petok_pkg::CH_EQ, petok_pkg::K_EQUAL, 1'b1, petok_pkg::ERR_NONE);
              end else begin
                a_d = lit(petok_pkg::CH_EQ, petok_pkg::K_ANY, 1'b1, petok_pkg::ERR_NONE);
                idle_d = 1'b1;
              end
            end
            M_SLASH: begin
              if (stat_i.is_star) begin
                mode_d = M_BLOCK;
              end else if (stat_i.is_slash) begin
                mode_d = M_LINE;
              end else begin
                mode_d = M_IDLE;
                a_v_d  = 1'b1;
                a_d = lit(petok_pkg::CH_SLASH, petok_pkg::K_DIV, 1'b1, petok_pkg::ERR_NONE);
                idle_d = 1'b1;
              end
            end
            M_BLOCK: begin
              if (stat_i.is_star) mode_d = M_STAR;
            end
            M_STAR: begin
              if (stat_i.is_slash) begin
                mode_d = M_IDLE;
                a_v_d  = 1'b1;
                a_d = lit(petok_pkg::CH_SPACE, petok_pkg::K_WHITE, 1'b1, petok_pkg::ERR_NONE);
              end else if (!stat_i.is_star) begin
                mode_d = M_BLOCK;
              end
            end
            M_LINE: begin
              if (stat_i.is_nl) begin
                mode_d = M_IDLE;
                a_v_d  = 1'b1;
                a_d = lit(petok_pkg::CH_NL, petok_pkg::K_NEWL, 1'b1, petok_pkg::ERR_NONE);
              end
            end
            default: idle_req = 1'b1;
          endcase
          if (!idle_req) begin
            state_d = dump_d ? S_DUMP : chain(a_v_d, b_v_d, idle_d);
          end
        end
      end

      S_DUMP: begin
        // Stream the stored token one character per transfer
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.pop  = 1'b1;
          cmd_o.src  = petok_pkg::SRC_RAM;
          cmd_o.item = lit(petok_pkg::CH_NUL, pk_q, stat_i.dump_last, derr_q);
          if (stat_i.dump_last) state_d = chain(a_v_q, b_v_q, idle_q);
        end
      end

      S_CHA: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.item = a_q;
          state_d = chain(1'b0, b_v_q, idle_q);
        end
      end

      S_CHB: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.item = b_q;
          state_d = chain(1'b0, 1'b0, idle_q);
        end
      end

      S_TAIL: idle_req = 1'b1;

      default: state_d = S_IN;
    endcase

    // Decode a byte from idle: open a token or pass a single character
    if (idle_req) begin
      idle_emit = !(is_word || stat_i.cls == petok_pkg::K_SQ || stat_i.cls == petok_pkg::K_DQ ||
                    stat_i.cls == petok_pkg::K_NOT || stat_i.cls == petok_pkg::K_GREAT ||
                    stat_i.cls == petok_pkg::K_LESS || stat_i.cls == petok_pkg::K_EQUAL ||
                    stat_i.cls == petok_pkg::K_DIV);
      if (!idle_emit || stat_i.out_free) begin
        state_d = S_IN;
        mode_d  = M_IDLE;
        if (is_word) begin
          cmd_o.restart = 1'b1;
          pk_d   = stat_i.cls;
          mode_d = M_WORD;
        end else if (stat_i.cls == petok_pkg::K_SQ || stat_i.cls == petok_pkg::K_DQ) begin
          cmd_o.restart  = 1'b1;
          cmd_o.quote_ld = 1'b1;
          pk_d   = stat_i.cls;
          ovf_d  = 1'b0;
          mode_d = M_STR;
        end else if (stat_i.cls == petok_pkg::K_NOT) begin
          mode_d = M_NOT;
        end else if (stat_i.cls == petok_pkg::K_GREAT) begin
          mode_d = M_GT;
        end else if (stat_i.cls == petok_pkg::K_LESS) begin
          mode_d = M_LT;
        end else if (stat_i.cls == petok_pkg::K_EQUAL) begin
          mode_d = M_EQ;
        end else if (stat_i.cls == petok_pkg::K_DIV) begin
          mode_d = M_SLASH;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.src  = petok_pkg::SRC_BYTE;
          cmd_o.item = lit(petok_pkg::CH_NUL, stat_i.cls, 1'b1, petok_pkg::ERR_NONE);
        end
      end
    end
  end

  // Hold state, lexer mode and the emission plan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
      mode_q  <= M_IDLE;
      pk_q    <= '0;
      ovf_q   <= 1'b0;
      dump_q  <= 1'b0;
      derr_q  <= '0;
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      idle_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      pk_q    <= pk_d;
      ovf_q   <= ovf_d;
      dump_q  <= dump_d;
      derr_q  <= derr_d;
      a_v_q   <= a_v_d;
      b_v_q   <= b_v_d;
      idle_q  <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  a_take_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> state_q == S_EVAL)
    else $error("accepted byte not evaluated");
  a_ready_only_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.push)
    else $error("input taken while emitting");
  a_dump_from_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> (mode_q == M_IDLE || mode_q == M_WORD))
    else $error("dump while a string or operator is pending");

endmodule

`default_nettype wire

@@ rtl/preprocessor_expression_tokenizer_unit.sv @@
// Channel   Dir  Payload                                       Handshake
// in_i      in   src_byte[7:0], end_of_input                   valid/ready
// out_o     out  tok_char[7:0], tok_kind[5:0], tok_last,       valid/ready
//                tok_error[1:0]
//
// A byte passes through a capture state and then an evaluate state; a one-character token
// decoded from idle is loaded into the output register in the evaluate state itself.
// Every other emitted character passes through the single output register; a stored
// word or string streams from the token store one per cycle while the receiver is ready.
// A byte that ends a word or a pending operator is decoded in a later tail state.
// Output stalls hold the controller in its emit state; no input is taken then.
// Reset is asynchronous, active low; the token store needs no clearing.
`default_nettype none

module preprocessor_expression_tokenizer_unit #(
  parameter int TokenSize = petok_pkg::TOKEN_SIZE
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  petok_in_if.sink      in_i,
  petok_out_if.source   out_o
);

  petok_pkg::cmd_t  cmd;
  petok_pkg::stat_t stat;
  petok_pkg::item_t out_item;

  petok_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  petok_dp #(
    .TokenSize (TokenSize)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .src_byte_i     (in_i.src_byte),
    .end_of_input_i (in_i.end_of_input),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_item_o     (out_item)
  );

  assign out_o.tok_char  = out_item.ch;
  assign out_o.tok_kind  = out_item.kind;
  assign out_o.tok_last  = out_item.last;
  assign out_o.tok_error = out_item.err;

endmodule

`default_nettype wire

@@ sim/tok_checker.sv @@
module tok_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  petok_in_if       in_mon,
  petok_out_if      out_mon,
  output int        fail_count_o,
  output int        pending_o,
  output int        tok_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import petok_pkg::*;

  typedef enum logic [3:0] {
    LX_IDLE, LX_WORD, LX_STR, LX_ESC, LX_NOT, LX_GT, LX_LT, LX_EQ,
    LX_SLASH, LX_BLOCK, LX_STAR, LX_LINE
  } lex_e;

  // Predictor state
  lex_e       mode_q;
  logic [7:0] word_buf [TOKEN_SIZE];
  int         word_len;
  logic [5:0] word_kind;
  logic [7:0] quote_ch;
  logic       str_long;

  item_t tok_fifo [$];
  int    fails;

  assign fail_count_o = fails;
  assign pending_o    = tok_fifo.size();

  function automatic logic [5:0] char_class(logic [7:0] b);
    logic [5:0] k;
    k = K_ANY;
    if (b[7]) k = K_ANY;
    else if (b >= "0" && b <= "9") k = K_DIGIT;
    else if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_") k = K_ALPHA;
    else begin
      case (b)
        8'h00: k = K_END;
        8'h09, 8'h20: k = K_WHITE;
        8'h0A, 8'h14: k = K_NEWL;
        "!": k = K_NOT;   "\"": k = K_DQ;  "#": k = K_POUND; "%": k = K_MOD;
        "&": k = K_AND;   "'": k = K_SQ;   "(": k = K_LPAR;  ")": k = K_RPAR;
        "*": k = K_MULT;  "+": k = K_ADD;  ",": k = K_COMMA; "-": k = K_SUB;
        "/": k = K_DIV;   ":": k = K_COLON; "<": k = K_LESS; "=": k = K_EQUAL;
        ">": k = K_GREAT; "?": k = K_QMARK; "\\": k = K_BSL; "^": k = K_XOR;
        "|": k = K_OR;    "~": k = K_COMPL;
        default: k = K_ANY;
      endcase
    end
    return k;
  endfunction

  task automatic push_tok(logic [7:0] c, logic [5:0] k, logic l, logic [1:0] e);
    item_t it;
    it.ch = c; it.kind = k; it.last = l; it.err = e;
    tok_fifo.push_back(it);
  endtask

  task automatic dump_word(logic [5:0] k, logic [1:0] e);
    for (int i = 0; i < word_len; i++) push_tok(word_buf[i], k, i + 1 == word_len, e);
    word_len = 0;
  endtask

  task automatic keep_byte(logic [7:0] b);
    if (word_len < TOKEN_SIZE) begin
      word_buf[word_len] = b;
      word_len++;
    end
  endtask

  task automatic start_byte(logic [7:0] b);
    logic [5:0] k;
    k = char_class(b);
    mode_q = LX_IDLE;
    case (k)
      K_DIGIT, K_ALPHA: begin
        word_len = 0; keep_byte(b); word_kind = k; mode_q = LX_WORD;
      end
      K_SQ, K_DQ: begin
        word_len = 0; keep_byte(b); quote_ch = b; word_kind = k;
        str_long = 1'b0; mode_q = LX_STR;
      end
      K_NOT:   mode_q = LX_NOT;
      K_GREAT: mode_q = LX_GT;
      K_LESS:  mode_q = LX_LT;
      K_EQUAL: mode_q = LX_EQ;
      K_DIV:   mode_q = LX_SLASH;
      default: push_tok(b, k, 1'b1, ERR_NONE);
    endcase
  endtask

  task automatic str_byte(logic [7:0] b);
    if (word_len < TOKEN_SIZE - 2) keep_byte(b);
    else str_long = 1'b1;
  endtask

  task automatic pair(logic [7:0] a, logic [7:0] b, logic [5:0] k);
    push_tok(a, k, 1'b0, ERR_NONE);
    push_tok(b, k, 1'b1, ERR_NONE);
    mode_q = LX_IDLE;
  endtask

  task automatic lex_byte(logic [7:0] b, logic eoi);
    logic [5:0] k;
    k = char_class(b);
    if (eoi) begin
      // Flush whatever is pending, then the end token
      case (mode_q)
        LX_WORD: dump_word(word_kind, ERR_NONE);
        LX_STR, LX_ESC, LX_LINE: push_tok(CH_NL, K_NEWL, 1'b1, ERR_NONE);
        LX_NOT:   push_tok(CH_BANG, K_NOT, 1'b1, ERR_NONE);
        LX_GT:    push_tok(CH_GT, K_GREAT, 1'b1, ERR_NONE);
        LX_LT:    push_tok(CH_LT, K_LESS, 1'b1, ERR_NONE);
        LX_EQ:    push_tok(CH_EQ, K_ANY, 1'b1, ERR_NONE);
        LX_SLASH: push_tok(CH_SLASH, K_DIV, 1'b1, ERR_NONE);
        LX_BLOCK, LX_STAR: push_tok(CH_SPACE, K_WHITE, 1'b1, ERR_OPEN);
        default: ;
      endcase
      word_len = 0;
      mode_q = LX_IDLE;
      push_tok(CH_NUL, K_END, 1'b1, ERR_NONE);
      return;
    end
    case (mode_q)
      LX_WORD:
        if (k == K_ALPHA || k == K_DIGIT) begin
          keep_byte(b);
          if (word_len >= TOKEN_SIZE) begin
            dump_word(word_kind, ERR_NONE);
            mode_q = LX_IDLE;
          end
        end else begin
          dump_word(word_kind, ERR_NONE);
          start_byte(b);
        end
      LX_STR:
        if (b == quote_ch) begin
          if (word_len >= TOKEN_SIZE) word_len = TOKEN_SIZE - 1;
          keep_byte(b);
          dump_word(word_kind, str_long ? ERR_LONG : ERR_NONE);
          str_long = 1'b0;
          mode_q = LX_IDLE;
        end else if (b == CH_NL) begin
          word_len = 0; str_long = 1'b0;
          push_tok(CH_NL, K_NEWL, 1'b1, ERR_NONE);
          mode_q = LX_IDLE;
        end else begin
          str_byte(b);
          if (b == CH_BSL) mode_q = LX_ESC;
        end
      LX_ESC: begin
        str_byte(b);
        mode_q = LX_STR;
      end
      LX_NOT:
        if (b == CH_EQ) pair(CH_BANG, CH_EQ, K_NEQ);
        else begin push_tok(CH_BANG, K_NOT, 1'b1, ERR_NONE); start_byte(b); end
      LX_GT:
        if (b == CH_GT) pair(CH_GT, CH_GT, K_RSH);
        else if (b == CH_EQ) pair(CH_GT, CH_EQ, K_GEQ);
        else begin push_tok(CH_GT, K_GREAT, 1'b1, ERR_NONE); start_byte(b); end
      LX_LT:
        if (b == CH_LT) pair(CH_LT, CH_LT, K_LSH);
        else if (b == CH_EQ) pair(CH_LT, CH_EQ, K_LEQ);
        else begin push_tok(CH_LT, K_LESS, 1'b1, ERR_NONE); start_byte(b); end
      LX_EQ:
        if (b == CH_EQ) pair(CH_EQ, CH_EQ, K_EQUAL);
        else begin push_tok(CH_EQ, K_ANY, 1'b1, ERR_NONE); start_byte(b); end
      LX_SLASH:
        if (b == CH_STAR) mode_q = LX_BLOCK;
        else if (b == CH_SLASH) mode_q = LX_LINE;
        else begin push_tok(CH_SLASH, K_DIV, 1'b1, ERR_NONE); start_byte(b); end
      LX_BLOCK: if (b == CH_STAR) mode_q = LX_STAR;
      LX_STAR:
        if (b == CH_SLASH) begin
          push_tok(CH_SPACE, K_WHITE, 1'b1, ERR_NONE);
          mode_q = LX_IDLE;
        end else if (b != CH_STAR) mode_q = LX_BLOCK;
      LX_LINE:
        if (b == CH_NL) begin
          push_tok(CH_NL, K_NEWL, 1'b1, ERR_NONE);
          mode_q = LX_IDLE;
        end
      default: start_byte(b);
    endcase
  endtask

  // Predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    item_t want;
    if (!rst_ni) begin
      mode_q = LX_IDLE;
      word_len = 0; word_kind = K_END; quote_ch = '0; str_long = 1'b0;
      fails = 0;
      tok_seen_o = 0;
      tok_fifo.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        tok_seen_o = tok_seen_o + 1;
        if (tok_fifo.size() == 0) begin
          fails++;
          $display("%0t: unexpected token char %h kind %0d", $time,
                   out_mon.tok_char, out_mon.tok_kind);
        end else begin
          want = tok_fifo.pop_front();
          if (want.ch !== out_mon.tok_char || want.kind !== out_mon.tok_kind ||
              want.last !== out_mon.tok_last || want.err !== out_mon.tok_error) begin
            fails++;
            $display("%0t: mismatch expected ch=%h kind=%0d last=%0b err=%0d,",
                     $time, want.ch, want.kind, want.last, want.err,
                     " actual ch=%h kind=%0d last=%0b err=%0d", out_mon.tok_char,
                     out_mon.tok_kind, out_mon.tok_last, out_mon.tok_error);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) lex_byte(in_mon.src_byte, in_mon.end_of_input);
    end
  end
endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import petok_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, tok_seen;
  int   idle_cycles;
  int   sent;
  bit   hold_long;
  bit   timed_out;

  petok_in_if  in_ch ();
  petok_out_if out_ch ();

  preprocessor_expression_tokenizer_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch)
  );

  tok_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count_o(fail_count), .pending_o(pending), .tok_seen_o(tok_seen)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.src_byte = '0;
    in_ch.end_of_input = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    hold_long = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (150) @(posedge clk_i);
        hold_long = 1'b0;
      end
      mode = (sent / 40) % 3;
      if (mode == 0) out_ch.ready <= 1'b1;
      else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= ($urandom_range(0, 2) == 0);
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("preprocessor_expression_tokenizer_unit test failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic eoi);
    in_ch.valid <= 1'b1;
    in_ch.src_byte <= b;
    in_ch.end_of_input <= eoi;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
    // random gaps between bursts
    if ($urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_run(logic [7:0] b, int n);
    for (int i = 0; i < n; i++) send_byte(b, 1'b0);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = 8'("a" + $urandom_range(0, 25));
      1: b = 8'("0" + $urandom_range(0, 9));
      2: b = "\"";
      3: b = "/";
      4: b = "*";
      5: b = CH_NL;
      6: begin
        case ($urandom_range(0, 3))
          0: b = "=";
          1: b = "<";
          2: b = ">";
          default: b = "!";
        endcase
      end
      7: b = "\\";
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  initial begin
    idle_cycles = 0;
    sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: operators, comments, strings, caps, extremes
    send_text("!=!a>>>=>b<<<=<c===d/x");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("/* a **/ // line\n'x\\'y' \"ab\nq");
    send_run("z", 33);
    send_run("7", 32);
    send_byte("\"", 1'b0);
    send_run("s", 40);
    send_text("\\\"\"(\"open");
    send_byte(8'h00, 1'b1);
    send_text("/* never");
    send_byte(8'h00, 1'b1);
    send_text("!");
    send_byte(8'h00, 1'b1);

    // Pause until all expected tokens drained
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    // Long receiver hold-off while input keeps coming
    hold_long = 1'b1;
    send_text("abc + def * (12 - 3) >= x");

    // Random: mostly well-formed tokens, some noise
    while (sent < 350) begin
      case ($urandom_range(0, 7))
        0: send_run(8'("a" + $urandom_range(0, 25)), $urandom_range(1, 6));
        1: begin send_byte("\"", 1'b0);
             send_run(8'($urandom_range(32, 126)), $urandom_range(0, 8));
             send_byte("\"", 1'b0); end
        2: send_text("/* c */");
        3: send_text("// x\n");
        4: send_byte(pick_byte(), $urandom_range(0, 15) == 0);
        default: send_byte(pick_byte(), 1'b0);
      endcase
    end
    send_byte(8'h00, 1'b1);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d source bytes, checked %0d token characters", sent, tok_seen);
    if (fail_count == 0) $display("preprocessor_expression_tokenizer_unit test passed");
    else $display("preprocessor_expression_tokenizer_unit test failed");
    $finish;
  end
endmodule
